FILE: design/ffit_pkg.sv
// Package: shared types, widths and defaults of the first-fit track assigner.
package ffit_pkg;

	// default number of tracks
	localparam int unsigned MAX_TRACKS_DEF = 64;

	// payload field widths
	localparam int unsigned TIME_W = 31;
	localparam int unsigned END_W  = 32;
	localparam int unsigned TIDX_W = 6;
	localparam int unsigned TCNT_W = 7;

	// one result item
	typedef struct packed {
		logic [TIDX_W-1:0] track_index;
		logic              opened_track;
		logic              overflow;
		logic [TCNT_W-1:0] tracks_in_use;
	} ffit_res_t;

	// scan controller states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} ffit_state_t;

endpackage

FILE: design/first_fit_interval_track_assigner.sv
// Top level: first-fit interval track assigner.
//
// Intervals (start_time, span_length) enter on the in_valid/in_ready channel,
// sorted by start and then end. new_set clears all tracks before the item.
// Each item produces one result item on out_valid/out_ready: the chosen
// track, whether a track was opened, an overflow flag and the open count.
//
// Track end times live in a synchronous RAM of MAX_TRACKS words. The scan
// reads one stored end per cycle in creation order and stops at the first
// end at or before the start. One item is in work at a time; in_ready
// returns once the result moves to the output register, so the scan takes
// no new interval before the last result has left it. The result may wait
// in the output register while the next item scans.
//
// Reset clears the open-track count and all handshake state; the RAM is not
// cleared, since only entries below the open count are ever read. A stalled
// receiver holds the result in the output register, and the scan holds its
// finished result until the output register frees.
module first_fit_interval_track_assigner
	import ffit_pkg::*;
#(
	parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              new_set,
	input  logic [TIME_W-1:0] start_time,
	input  logic [TIME_W-1:0] span_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TIDX_W-1:0] track_index,
	output logic              opened_track,
	output logic              overflow,
	output logic [TCNT_W-1:0] tracks_in_use
);

	localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	logic             res_vld;
	logic             res_rdy;
	ffit_res_t        res;
	ffit_res_t        out_q;
	logic             out_valid_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [END_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [END_W-1:0] mem_rdata;

	ffit_scan #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.new_set    (new_set),
		.start_time (start_time),
		.span_length(span_length),
		.res_vld    (res_vld),
		.res_rdy    (res_rdy),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ffit_ram #(
		.WIDTH(END_W),
		.DEPTH(MAX_TRACKS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register
	assign res_rdy = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_rdy) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && res_vld) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign track_index   = out_q.track_index;
	assign opened_track  = out_q.opened_track;
	assign overflow      = out_q.overflow;
	assign tracks_in_use = out_q.tracks_in_use;

endmodule

FILE: design/ffit_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffit_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ffit_scan.sv
// Scan controller: walks the stored track ends in creation order and picks the first fit.
module ffit_scan
	import ffit_pkg::*;
#(
	parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF,
	localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
	localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              new_set,
	input  logic [TIME_W-1:0] start_time,
	input  logic [TIME_W-1:0] span_length,
	output logic              res_vld,
	input  logic              res_rdy,
	output ffit_res_t         res,
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output logic [END_W-1:0]  mem_wdata,
	output logic [IDX_W-1:0]  mem_raddr,
	input  logic [END_W-1:0]  mem_rdata
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKS);

	ffit_state_t       state_q;
	logic [TIME_W-1:0] start_q;
	logic [END_W-1:0]  end_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [IDX_W-1:0]  chosen_q;
	logic              opened_q;
	logic              ovf_q;

	logic accept;
	logic issue;
	logic hit;
	logic exhausted;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign hit       = (state_q == ST_SCAN) && cmp_vld_s1 && (mem_rdata <= {1'b0, start_q});
	assign exhausted = (state_q == ST_SCAN) && !cmp_vld_s1 && !issue;

	// memory access: one read per scan cycle, write back of the new end
	assign mem_raddr = rd_idx_q[IDX_W-1:0];
	assign mem_we    = (state_q == ST_WRITE) && !ovf_q;
	assign mem_waddr = chosen_q;
	assign mem_wdata = end_q;

	// result item
	assign res_vld           = (state_q == ST_WRITE);
	assign res.track_index   = TIDX_W'(chosen_q);
	assign res.opened_track  = opened_q;
	assign res.overflow      = ovf_q;
	assign res.tracks_in_use = TCNT_W'(count_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (new_set) begin
							count_q <= '0;
						end
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue;
					rd_idx_q   <= rd_idx_q + CNT_W'(issue);
					if (hit) begin
						state_q <= ST_WRITE;
					end else if (exhausted) begin
						if (count_q < MAX_CNT) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (res_rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and scan decision
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_time;
			end_q   <= END_W'(start_time) + END_W'(span_length);
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (hit) begin
			chosen_q <= cmp_idx_s1;
			opened_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (exhausted) begin
			if (count_q < MAX_CNT) begin
				chosen_q <= count_q[IDX_W-1:0];
				opened_q <= 1'b1;
				ovf_q    <= 1'b0;
			end else begin
				chosen_q <= '0;
				opened_q <= 1'b0;
				ovf_q    <= 1'b1;
			end
		end
	end

endmodule

FILE: design/ffit_chk.sv
// Port checker for the first-fit track assigner, bound to the top level.
module ffit_chk
	import ffit_pkg::*;
#(
	parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TIDX_W-1:0] track_index,
	input logic              opened_track,
	input logic              overflow,
	input logic [TCNT_W-1:0] tracks_in_use
);

	localparam logic [TCNT_W-1:0] MAX_CNT = TCNT_W'(MAX_TRACKS);

	// one item in work at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(track_index)
			&& $stable(overflow) && $stable(tracks_in_use))
		else $error("stalled result item changed");

	// overflow only with all tracks open, and reports track zero
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !opened_track && track_index == '0
			&& tracks_in_use == MAX_CNT)
		else $error("overflow item malformed");

	// an opened track is the newest one
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opened_track |->
			track_index == TIDX_W'(tracks_in_use - 1'b1))
		else $error("opened track is not the last track");

	// a reused track is an open one
	a_reuse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !opened_track && !overflow && MAX_TRACKS <= 64 |->
			TCNT_W'(track_index) < tracks_in_use)
		else $error("reused track beyond open count");

endmodule

bind first_fit_interval_track_assigner ffit_chk #(.MAX_TRACKS(MAX_TRACKS)) u_ffit_chk (.*);
